FILE: rtl/keyword_lexer_stream_core_macros.svh
// Assertion helpers for the keyword lexer core.
// Both macros expect clk_i and rst_ni in scope.
`ifndef KEYWORD_LEXER_STREAM_CORE_MACROS_SVH
`define KEYWORD_LEXER_STREAM_CORE_MACROS_SVH

// Same-cycle implication.
`define KLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/kls_pkg.sv
package kls_pkg;

  localparam int unsigned KW_NUM   = 19;
  localparam int unsigned KW_SLOTS = 10;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned LINE_W   = 16;

  // Output queue; must hold at least the two words one byte can produce.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_LW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_KEYWORD = 2'd0,
    KIND_NUMBER  = 2'd1,
    KIND_IDENT   = 2'd2,
    KIND_SYMBOL  = 2'd3
  } token_kind_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } kls_in_t;

  typedef struct packed {
    token_kind_e        token_kind;
    logic [4:0]         keyword_index;
    logic [LEN_W-1:0]   token_length;
    logic [7:0]         symbol_byte;
    logic [LINE_W-1:0]  line_number;
    logic               last_of_run;
  } kls_out_t;

  // Up to two tokens per accepted byte, packed from the first slot.
  typedef struct packed {
    logic [1:0] count;
    kls_out_t   first;
    kls_out_t   second;
  } kls_push_t;

  typedef struct packed {
    logic              word_pending;
    logic [LINE_W-1:0] line_count;
  } kls_scan_stat_t;

  typedef struct packed {
    logic [FIFO_LW-1:0] level;
  } kls_fifo_stat_t;

  // Keyword text, first character in the top byte, zero padded.
  function automatic logic [8*KW_SLOTS-1:0] kw_text(input logic [4:0] idx);
    logic [8*KW_SLOTS-1:0] t;
    case (idx)
      5'd0:    t = {"program",   24'h0};
      5'd1:    t = {"begin",     40'h0};
      5'd2:    t = {"end",       56'h0};
      5'd3:    t = {"var",       56'h0};
      5'd4:    t = {"integer",   24'h0};
      5'd5:    t = {"real",      48'h0};
      5'd6:    t = {"boolean",   24'h0};
      5'd7:    t = {"if",        64'h0};
      5'd8:    t = {"then",      48'h0};
      5'd9:    t = {"else",      48'h0};
      5'd10:   t = {"while",     40'h0};
      5'd11:   t = {"do",        64'h0};
      5'd12:   t = {"for",       56'h0};
      5'd13:   t = {"to",        64'h0};
      5'd14:   t = {"downto",    32'h0};
      5'd15:   t = {"repeat",    32'h0};
      5'd16:   t = {"until",     40'h0};
      5'd17:   t = {"procedure",  8'h0};
      5'd18:   t = {"function",  16'h0};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] idx);
    logic [3:0] n;
    case (idx)
      5'd0, 5'd4, 5'd6:                n = 4'd7;
      5'd1, 5'd10, 5'd16:              n = 4'd5;
      5'd2, 5'd3, 5'd12:               n = 4'd3;
      5'd5, 5'd8, 5'd9:                n = 4'd4;
      5'd7, 5'd11, 5'd13:              n = 4'd2;
      5'd14, 5'd15:                    n = 4'd6;
      5'd17:                           n = 4'd9;
      5'd18:                           n = 4'd8;
      default:                         n = 4'd0;
    endcase
    return n;
  endfunction

  // Character of keyword idx at position pos (pos below KW_SLOTS).
  function automatic logic [7:0] kw_char(input logic [4:0] idx, input logic [3:0] pos);
    logic [8*KW_SLOTS-1:0] t;
    t = kw_text(idx) << {pos, 3'b000};
    return t[8*KW_SLOTS-1 -: 8];
  endfunction

endpackage

FILE: rtl/kls_scan.sv
module kls_scan #(
  parameter int unsigned MAX_WORD_LEN = 127
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  kls_pkg::kls_in_t        in_data_i,
  output kls_pkg::kls_push_t      push_o,
  output kls_pkg::kls_scan_stat_t stat_o
);
  import kls_pkg::*;

  localparam int unsigned LenCapInt = (MAX_WORD_LEN > 127) ? 127 : MAX_WORD_LEN;
  localparam logic [LEN_W-1:0] LenCap = LEN_W'(LenCapInt);
  localparam logic [7:0] ChNewline    = 8'h0A;
  localparam logic [7:0] ChUnderscore = 8'h5F;
  localparam logic [LINE_W-1:0] LineMax = '1;

  logic [KW_NUM-1:0] mask_q, mask_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              digit_q, digit_d;
  logic [LINE_W-1:0] line_q, line_d;

  logic [7:0]        c;
  logic              is_digit, is_word, is_space, pending;
  logic              kw_hit;
  logic [4:0]        kw_idx;
  logic [KW_NUM-1:0] base_mask;
  kls_out_t          word_res, sym_res;

  assign c        = in_data_i.char_byte;
  assign is_digit = (c >= "0") && (c <= "9");
  assign is_word  = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
                    is_digit || (c == ChUnderscore);
  assign is_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  assign pending  = (len_q != '0);

  // Lowest surviving candidate whose length matches the word.
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int i = KW_NUM - 1; i >= 0; i--) begin
      if (mask_q[i] && ({3'b000, kw_len(5'(i))} == len_q)) begin
        kw_hit = 1'b1;
        kw_idx = 5'(i);
      end
    end
  end

  always_comb begin
    word_res.token_kind    = kw_hit ? KIND_KEYWORD : (digit_q ? KIND_NUMBER : KIND_IDENT);
    word_res.keyword_index = kw_hit ? kw_idx : 5'd0;
    word_res.token_length  = len_q;
    word_res.symbol_byte   = 8'd0;
    word_res.line_number   = line_q;
    word_res.last_of_run   = 1'b0;

    sym_res.token_kind    = KIND_SYMBOL;
    sym_res.keyword_index = 5'd0;
    sym_res.token_length  = LEN_W'(1);
    sym_res.symbol_byte   = c;
    sym_res.line_number   = line_q;
    sym_res.last_of_run   = 1'b1;
  end

  always_comb begin
    push_o.count  = 2'd0;
    push_o.first  = word_res;
    push_o.second = sym_res;
    if (in_data_i.end_of_input) begin
      push_o.first.last_of_run = 1'b1;
      push_o.count             = pending ? 2'd1 : 2'd0;
    end else if (!is_word) begin
      if (pending) begin
        push_o.first.last_of_run = is_space;
        push_o.count             = is_space ? 2'd1 : 2'd2;
      end else begin
        push_o.first = sym_res;
        push_o.count = is_space ? 2'd0 : 2'd1;
      end
    end
  end

  assign base_mask = pending ? mask_q : '1;

  always_comb begin
    mask_d  = mask_q;
    len_d   = len_q;
    digit_d = digit_q;
    line_d  = line_q;
    if (in_data_i.end_of_input) begin
      mask_d  = '1;
      len_d   = '0;
      digit_d = 1'b0;
      line_d  = LINE_W'(1);
    end else if (is_word) begin
      for (int i = 0; i < KW_NUM; i++) begin
        mask_d[i] = base_mask[i] && (len_q < LEN_W'(KW_SLOTS)) &&
                    (kw_char(5'(i), len_q[3:0]) == c);
      end
      len_d   = (len_q < LenCap) ? len_q + LEN_W'(1) : len_q;
      digit_d = pending ? digit_q : is_digit;
    end else begin
      mask_d  = '1;
      len_d   = '0;
      digit_d = 1'b0;
      if ((c == ChNewline) && (line_q != LineMax)) begin
        line_d = line_q + LINE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '1;
      len_q   <= '0;
      digit_q <= 1'b0;
      line_q  <= LINE_W'(1);
    end else if (accept_i) begin
      mask_q  <= mask_d;
      len_q   <= len_d;
      digit_q <= digit_d;
      line_q  <= line_d;
    end
  end

  assign stat_o.word_pending = pending;
  assign stat_o.line_count   = line_q;

endmodule

FILE: rtl/kls_token_fifo.sv
module kls_token_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_en_i,
  input  kls_pkg::kls_push_t      push_i,
  output logic                    room_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output kls_pkg::kls_out_t       out_data_o,
  output kls_pkg::kls_fifo_stat_t stat_o
);
  import kls_pkg::*;

  kls_out_t            mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, wr_next;
  logic [FIFO_LW-1:0]  level_q, level_d;
  logic                pop;
  logic [1:0]          n_push;

  assign n_push  = push_en_i ? push_i.count : 2'd0;
  assign pop     = out_valid_o && out_ready_i;
  assign wr_next = wr_ptr_q + FIFO_AW'(1);
  assign wr_ptr_d = wr_ptr_q + FIFO_AW'(n_push);
  assign level_d  = level_q + FIFO_LW'(n_push) - FIFO_LW'(pop);

  // Room for the worst case of two words, judged on registered level only.
  assign room_o      = (level_q <= FIFO_LW'(FIFO_DEPTH - 2));
  assign out_valid_o = (level_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      level_q  <= level_d;
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
    end
  end

  assign stat_o.level = level_q;

endmodule

FILE: rtl/keyword_lexer_stream_core.sv
// Each token word is registered in the token queue when its byte is accepted and reaches the output behind older words.
// Throughput: one byte per cycle while the token queue has room for two words;
//   output drains one word per cycle while out_ready_i is high, and a word-plus-symbol byte yields two words.
// Reset (async, active low): line count 1, no word pending, all keyword
//   candidates set, token queue empty.
`include "keyword_lexer_stream_core_macros.svh"

module keyword_lexer_stream_core #(
  parameter int unsigned MAX_WORD_LEN = 127
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kls_pkg::kls_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output kls_pkg::kls_out_t out_data_o
);
  import kls_pkg::*;

  logic           accept;
  kls_push_t      push;
  kls_scan_stat_t scan_stat;
  kls_fifo_stat_t fifo_stat;

  // A byte is taken when it is valid and the queue can absorb both possible tokens.
  assign accept = in_valid_i && in_ready_o;

  // Character classification, keyword candidate mask, word length and
  // line counter; forms the token words for the current byte.
  kls_scan #(
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push),
    .stat_o    (scan_stat)
  );

  // Result register bank: decouples the two sides so a waiting token
  // never stalls intake until the queue nears full.
  kls_token_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_en_i   (accept),
    .push_i      (push),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .stat_o      (fifo_stat)
  );

  // Queue never overfills.
  `KLS_ASSERT_NOW(a_fifo_bound, 1'b1, fifo_stat.level <= FIFO_LW'(FIFO_DEPTH), "token queue overflow")
  // Output valid tracks queue occupancy.
  `KLS_ASSERT_NOW(a_valid_level, 1'b1, out_valid_o == (fifo_stat.level != '0), "valid/level mismatch")
  // End of input clears the word and restarts the line count.
  `KLS_ASSERT_NEXT(a_eoi_reset, accept && in_data_i.end_of_input, !scan_stat.word_pending && (scan_stat.line_count == LINE_W'(1)), "end of input did not reset scan state")
  // Line count never drops to zero.
  `KLS_ASSERT_NOW(a_line_nonzero, 1'b1, scan_stat.line_count != '0, "line count reached zero")

endmodule
